FILE: rtl/scar_pkg.sv
// Shared types and constants for the stereo comb/allpass reverb.
// Used by the multiplier, the RAM sizing and the top level; no dependencies.
`default_nettype none
package scar_pkg;

  localparam int COMB_LINE_DEPTH    = 2048;
  localparam int ALLPASS_LINE_DEPTH = 1024;
  localparam int COMB_COUNT         = 8;
  localparam int ALLPASS_COUNT      = 4;

  localparam int CPOS_W     = $clog2(COMB_LINE_DEPTH);
  localparam int APOS_W     = $clog2(ALLPASS_LINE_DEPTH);
  localparam int COMB_IDX_W = 3;
  localparam int AP_IDX_W   = 2;
  localparam int C_ADDR_W   = 1 + COMB_IDX_W + CPOS_W;
  localparam int A_ADDR_W   = 1 + AP_IDX_W + APOS_W;
  localparam int C_DEPTH    = 2 ** C_ADDR_W;
  localparam int A_DEPTH    = 2 ** A_ADDR_W;

  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 29;
  localparam int COEF_W   = 30;
  localparam int PROD_W   = 34;
  localparam int SPREAD_W = 9;
  localparam int FRAC_W   = 28;

  localparam logic [CPOS_W-1:0] COMB_BASE [8] = '{
    CPOS_W'(1116), CPOS_W'(1188), CPOS_W'(1277), CPOS_W'(1356),
    CPOS_W'(1422), CPOS_W'(1491), CPOS_W'(1557), CPOS_W'(1617)
  };
  localparam logic [APOS_W-1:0] AP_BASE [4] = '{
    APOS_W'(556), APOS_W'(441), APOS_W'(341), APOS_W'(225)
  };

  localparam logic [2:0] REG_BLEND  = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_DAMP   = 3'd2;
  localparam logic [2:0] REG_FB     = 3'd3;
  localparam logic [2:0] REG_AP_FB  = 3'd4;
  localparam logic [2:0] REG_SPREAD = 3'd5;

  typedef struct packed {
    logic                       en;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [COEF_W-1:0]   b;
  } mul_req_t;

endpackage
`default_nettype wire

FILE: rtl/scar_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; width and depth come from its parameters.
`default_nettype none
module scar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/scar_mul.sv
// Shared Q28 multiplier: registered floor(a*b / 2^28), held when not enabled.
// Depends on scar_pkg for the request type and widths.
`default_nettype none
module scar_mul (
  input  wire logic                                clk,
  input  wire scar_pkg::mul_req_t                  req,
  output logic signed [scar_pkg::PROD_W-1:0]       p
);

  logic signed [scar_pkg::SAMPLE_W+scar_pkg::COEF_W-1:0] prod;

  assign prod = req.a * req.b;

  // Taking the upper bits of the two's complement product is a floor shift.
  always_ff @(posedge clk) begin
    if (req.en) begin
      p <= prod[scar_pkg::SAMPLE_W+scar_pkg::COEF_W-1:scar_pkg::FRAC_W];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stereo_comb_allpass_reverb_unit.sv
// Top level of the stereo reverb: sequencer, filter state and output mix.
// Depends on scar_pkg, scar_ram (delay lines) and scar_mul (shared multiplier).
//
// Usage:
// Input channel in_valid/in_ready/mono_in carries one Q28 mono sample per
// transaction. Output channel out_valid/out_ready/left_out/right_out returns
// one saturated stereo pair per input sample, in order.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data is always
// ready; index 0..5 selects blend, width, damping, comb feedback, allpass
// feedback and spread. Other indexes are ignored. Write only while idle.
// All filter arithmetic runs through one registered multiplier: per channel,
// each comb filter steps through S_CRD..S_CW and each allpass filter through
// S_ARD..S_AW, then the mix runs S_M0..S_M7. A new sample is accepted only
// in S_IDLE, after the previous one has reached the output register.
// Reset: a clearing pass zeroes the comb and allpass delay
// memories, one entry per cycle; in_ready stays low during it.
// Stall: a finished result waits in the output register; the next sample is
// accepted meanwhile, and the block holds its last mix step until the
// previous result has been taken.
`default_nettype none
module stereo_comb_allpass_reverb_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [scar_pkg::SAMPLE_W-1:0] mono_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [scar_pkg::SAMPLE_W-1:0]      left_out,
  output logic signed [scar_pkg::SAMPLE_W-1:0]      right_out,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [scar_pkg::GAIN_W-1:0]         cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLEAR = 5'd1;
  localparam logic [4:0] S_CRD   = 5'd2;
  localparam logic [4:0] S_CY    = 5'd3;
  localparam logic [4:0] S_CL    = 5'd4;
  localparam logic [4:0] S_CS    = 5'd5;
  localparam logic [4:0] S_CF    = 5'd6;
  localparam logic [4:0] S_CW    = 5'd7;
  localparam logic [4:0] S_ARD   = 5'd8;
  localparam logic [4:0] S_AB    = 5'd9;
  localparam logic [4:0] S_AW    = 5'd10;
  localparam logic [4:0] S_M0    = 5'd11;
  localparam logic [4:0] S_M1    = 5'd12;
  localparam logic [4:0] S_M2    = 5'd13;
  localparam logic [4:0] S_M3    = 5'd14;
  localparam logic [4:0] S_M4    = 5'd15;
  localparam logic [4:0] S_M5    = 5'd16;
  localparam logic [4:0] S_M6    = 5'd17;
  localparam logic [4:0] S_M7    = 5'd18;

  localparam logic signed [30:0] ONE_Q28 = 31'sd268435456;

  function automatic logic signed [scar_pkg::SAMPLE_W-1:0] sat32(
    input logic signed [scar_pkg::PROD_W:0] v
  );
    logic signed [scar_pkg::PROD_W:0] hi;
    logic signed [scar_pkg::PROD_W:0] lo;
    hi = (scar_pkg::PROD_W+1)'(32'sh7fffffff);
    lo = -(scar_pkg::PROD_W+1)'(35'sh80000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[scar_pkg::SAMPLE_W-1:0];
  endfunction

  logic [4:0] state;
  logic [scar_pkg::C_ADDR_W-1:0] clr;
  logic ch;
  logic [scar_pkg::COMB_IDX_W-1:0] n;
  logic [scar_pkg::CPOS_W-1:0] pos;

  logic [scar_pkg::GAIN_W-1:0] blend, width, damp, fb, ap_fb;
  logic [scar_pkg::SPREAD_W-1:0] spread;

  logic signed [scar_pkg::SAMPLE_W-1:0] mono, x, acc, tmp, bval, wl, inl, inr, lo_hold;
  logic signed [scar_pkg::PROD_W-1:0] dm;
  logic signed [scar_pkg::SAMPLE_W-1:0] lp [2*scar_pkg::COMB_COUNT];
  logic [scar_pkg::COMB_IDX_W:0] li;

  logic signed [scar_pkg::COEF_W-1:0] omd, wet, wet1, wet2;
  logic signed [30:0] w_diff;
  logic [scar_pkg::SPREAD_W-1:0] spread_eff;
  logic [scar_pkg::CPOS_W-1:0] c_rd_pos;
  logic [scar_pkg::APOS_W-1:0] a_rd_pos;
  logic [scar_pkg::AP_IDX_W-1:0] an;

  scar_pkg::mul_req_t mreq;
  logic signed [scar_pkg::PROD_W-1:0] p;
  logic signed [scar_pkg::SAMPLE_W-1:0] pl;

  logic c_we, a_we;
  logic [scar_pkg::C_ADDR_W-1:0] c_waddr, c_raddr;
  logic [scar_pkg::A_ADDR_W-1:0] a_waddr, a_raddr;
  logic [scar_pkg::SAMPLE_W-1:0] c_wdata, a_wdata, c_rdata, a_rdata;
  logic signed [scar_pkg::SAMPLE_W-1:0] ro_val;
  logic load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign pl        = p[scar_pkg::SAMPLE_W-1:0];
  assign an        = n[scar_pkg::AP_IDX_W-1:0];
  assign li        = {ch, n};

  // Divide by eight, truncating toward zero.
  assign x = (mono + (mono[scar_pkg::SAMPLE_W-1] ? 32'sd7 : 32'sd0)) >>> 3;

  // Complementary gains can go negative for register values above one.
  assign omd    = scar_pkg::COEF_W'(ONE_Q28 - $signed({2'b00, damp}));
  assign wet    = scar_pkg::COEF_W'(ONE_Q28 - $signed({2'b00, blend}));
  assign wet1   = scar_pkg::COEF_W'({2'b00, width[scar_pkg::GAIN_W-1:1]} + 30'd134217728);
  assign w_diff = ONE_Q28 - $signed({2'b00, width});
  assign wet2   = scar_pkg::COEF_W'((w_diff + (w_diff[30] ? 31'sd1 : 31'sd0)) >>> 1);

  assign spread_eff = ch ? spread : '0;
  assign c_rd_pos = pos - scar_pkg::COMB_BASE[n] - scar_pkg::CPOS_W'(spread_eff);
  assign a_rd_pos = pos[scar_pkg::APOS_W-1:0] - scar_pkg::AP_BASE[an]
                    - scar_pkg::APOS_W'(spread_eff);

  assign c_raddr = {ch, n, c_rd_pos};
  assign a_raddr = {ch, an, a_rd_pos};

  always_comb begin
    c_we    = 1'b0;
    a_we    = 1'b0;
    c_waddr = {ch, n, pos};
    a_waddr = {ch, an, pos[scar_pkg::APOS_W-1:0]};
    c_wdata = x + pl;
    a_wdata = acc + pl;
    if (state == S_CLEAR) begin
      c_we    = 1'b1;
      a_we    = 1'b1;
      c_waddr = clr;
      a_waddr = clr[scar_pkg::A_ADDR_W-1:0];
      c_wdata = '0;
      a_wdata = '0;
    end else if (state == S_CW) begin
      c_we = 1'b1;
    end else if (state == S_AW) begin
      a_we = 1'b1;
    end
  end

  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = '0;
    mreq.b  = '0;
    unique case (state)
      S_CY: begin mreq.en = 1'b1; mreq.a = c_rdata;  mreq.b = omd; end
      S_CL: begin mreq.en = 1'b1; mreq.a = lp[li];   mreq.b = {1'b0, damp}; end
      S_CF: begin mreq.en = 1'b1; mreq.a = lp[li];   mreq.b = {1'b0, fb}; end
      S_AB: begin mreq.en = 1'b1; mreq.a = a_rdata;  mreq.b = {1'b0, ap_fb}; end
      S_M0: begin mreq.en = 1'b1; mreq.a = wl;       mreq.b = wet1; end
      S_M1: begin mreq.en = 1'b1; mreq.a = acc;      mreq.b = wet2; end
      S_M2: begin mreq.en = 1'b1; mreq.a = wl;       mreq.b = wet2; end
      S_M3: begin mreq.en = 1'b1; mreq.a = acc;      mreq.b = wet1; end
      S_M4: begin mreq.en = 1'b1; mreq.a = mono;     mreq.b = {1'b0, blend}; end
      S_M5: begin mreq.en = 1'b1; mreq.a = inl;      mreq.b = wet; end
      S_M6: begin mreq.en = 1'b1; mreq.a = inr;      mreq.b = wet; end
      default: begin end
    endcase
  end

  assign ro_val   = sat32((scar_pkg::PROD_W+1)'(dm) + (scar_pkg::PROD_W+1)'(p));
  assign load_out = (state == S_M7) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      blend  <= scar_pkg::GAIN_W'(53687091);
      width  <= scar_pkg::GAIN_W'(53687091);
      damp   <= scar_pkg::GAIN_W'(53687091);
      fb     <= scar_pkg::GAIN_W'(53687091);
      ap_fb  <= scar_pkg::GAIN_W'(134217728);
      spread <= scar_pkg::SPREAD_W'(23);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scar_pkg::REG_BLEND:  blend  <= cfg_data;
        scar_pkg::REG_WIDTH:  width  <= cfg_data;
        scar_pkg::REG_DAMP:   damp   <= cfg_data;
        scar_pkg::REG_FB:     fb     <= cfg_data;
        scar_pkg::REG_AP_FB:  ap_fb  <= cfg_data;
        scar_pkg::REG_SPREAD: spread <= cfg_data[scar_pkg::SPREAD_W-1:0];
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      ch        <= 1'b0;
      n         <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 2*scar_pkg::COMB_COUNT; i++) begin
        lp[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mono  <= mono_in;
            acc   <= '0;
            ch    <= 1'b0;
            n     <= '0;
            state <= S_CRD;
          end
        end
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_CRD: state <= S_CY;
        S_CY: begin
          acc   <= acc + $signed(c_rdata);
          state <= S_CL;
        end
        S_CL: begin
          tmp   <= pl;
          state <= S_CS;
        end
        S_CS: begin
          lp[li] <= tmp + pl;
          state  <= S_CF;
        end
        S_CF: state <= S_CW;
        S_CW: begin
          if (n == scar_pkg::COMB_IDX_W'(scar_pkg::COMB_COUNT - 1)) begin
            n     <= '0;
            state <= S_ARD;
          end else begin
            n     <= n + 1'b1;
            state <= S_CRD;
          end
        end
        S_ARD: state <= S_AB;
        S_AB: begin
          bval  <= a_rdata;
          state <= S_AW;
        end
        S_AW: begin
          if (an == scar_pkg::AP_IDX_W'(scar_pkg::ALLPASS_COUNT - 1)) begin
            n <= '0;
            if (!ch) begin
              wl    <= bval - acc;
              acc   <= '0;
              ch    <= 1'b1;
              state <= S_CRD;
            end else begin
              acc   <= bval - acc;
              state <= S_M0;
            end
          end else begin
            n     <= n + 1'b1;
            acc   <= bval - acc;
            state <= S_ARD;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          tmp   <= pl;
          state <= S_M2;
        end
        S_M2: begin
          inl   <= tmp + pl;
          state <= S_M3;
        end
        S_M3: begin
          tmp   <= pl;
          state <= S_M4;
        end
        S_M4: begin
          inr   <= tmp + pl;
          state <= S_M5;
        end
        S_M5: begin
          dm    <= p;
          state <= S_M6;
        end
        S_M6: begin
          lo_hold <= sat32((scar_pkg::PROD_W+1)'(dm) + (scar_pkg::PROD_W+1)'(p));
          state   <= S_M7;
        end
        S_M7: begin
          if (load_out) begin
            left_out  <= lo_hold;
            right_out <= ro_val;
            out_valid <= 1'b1;
            pos       <= pos + 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  scar_mul u_mul (
    .clk (clk),
    .req (mreq),
    .p   (p)
  );

  scar_ram #(.WIDTH(scar_pkg::SAMPLE_W), .DEPTH(scar_pkg::C_DEPTH)) u_comb_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  scar_ram #(.WIDTH(scar_pkg::SAMPLE_W), .DEPTH(scar_pkg::A_DEPTH)) u_ap_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_CRD)
    else $error("accepted sample did not start the comb sequence");

  a_pos_only_on_output: assert property (@(posedge clk) disable iff (rst)
    !$stable(pos) |-> $past(load_out))
    else $error("write position moved without a finished result");

  a_mix_on_right: assert property (@(posedge clk) disable iff (rst)
    state == S_M0 |-> ch)
    else $error("mix started before the right channel ran");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_M7 |-> !mreq.en)
    else $error("multiplier enabled while its result must hold");

endmodule
`default_nettype wire
